>>> rtl/core/fptb_pkg.sv
package fptb_pkg;

  localparam int MAX_POOL_TABLES   = 256;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int TBL_W             = $clog2(MAX_POOL_TABLES);
  localparam int SLOT_W            = $clog2(ENTRIES_PER_TABLE);
  localparam int MEM_DEPTH         = MAX_POOL_TABLES * ENTRIES_PER_TABLE;
  localparam int MEM_AW            = TBL_W + SLOT_W;

  localparam int ENTRY_W   = 48;
  localparam int OFS_W     = 12;
  localparam int PAGE_W    = ENTRY_W - OFS_W;
  localparam int ATTR_W    = 12;
  localparam int CNT_W     = 8;
  localparam int POOL_W    = 9;
  localparam int RTBL_W    = 8;
  localparam int CFG_W     = 36;
  localparam int CFG_IDX_W = 1;
  localparam int LVL_W     = 2;
  localparam int MAX_FREE  = 255;

  localparam logic [OFS_W-1:0]  LINK_FLAGS       = 12'h003;
  localparam logic [SLOT_W-1:0] HIGH_HALF_OFFSET = SLOT_W'(256);
  localparam logic [CNT_W-1:0]  MIN_FREE         = 8'd3;
  localparam logic [POOL_W-1:0] POOL_RESET       = 9'd256;
  localparam logic [LVL_W-1:0]  LVL_LAST         = 2'd2;

  localparam logic REQ_MAP       = 1'b0;
  localparam logic REQ_READ      = 1'b1;
  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE   = 1'b0,
    CFG_POOL_TABLES = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              req_type;
    logic [47:0]       virt_addr;
    logic              high_half;
    logic [ATTR_W-1:0] page_attr;
    logic [RTBL_W-1:0] read_table;
    logic [SLOT_W-1:0] read_slot;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [ENTRY_W-1:0] read_data;
    logic [CNT_W-1:0]   tables_free;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [MEM_AW-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [MEM_AW-1:0]  raddr;
  } mem_cmd_t;

endpackage

>>> rtl/core/fptb_if.sv
interface fptb_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [47:0] virt_addr;
  logic        high_half;
  logic [11:0] page_attr;
  logic [7:0]  read_table;
  logic [8:0]  read_slot;

  modport source (output valid, req_type, virt_addr, high_half, page_attr, read_table,
                  read_slot, input ready);
  modport sink (input valid, req_type, virt_addr, high_half, page_attr, read_table,
                read_slot, output ready);
endinterface

interface fptb_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [47:0] read_data;
  logic [7:0]  tables_free;

  modport source (output valid, status, read_data, tables_free, input ready);
  modport sink (input valid, status, read_data, tables_free, output ready);
endinterface

>>> rtl/core/fptb_ram.sv
module fptb_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/fptb_walk.sv
module fptb_walk (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fptb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fptb_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fptb_pkg::req_t                   in_item,
  output logic                             res_valid,
  input  logic                             res_ready,
  output fptb_pkg::res_t                   res_item,
  output fptb_pkg::mem_cmd_t               mem_cmd,
  input  logic [fptb_pkg::ENTRY_W-1:0]     mem_rdata
);
  import fptb_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_EV    = 6'b001000,
    S_LEAF  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t             state;
  logic [MEM_AW-1:0]  clr_addr;
  logic [PAGE_W-1:0]  pool_base;
  logic [POOL_W-1:0]  pool_tables;
  logic [CNT_W-1:0]   free_cnt;
  logic               is_read;
  logic [PAGE_W-1:0]  va_pg;
  logic [ATTR_W-1:0]  attr;
  logic [SLOT_W-1:0]  idx4;
  logic [SLOT_W-1:0]  rd_slot;
  logic [LVL_W-1:0]   lvl;
  logic [TBL_W-1:0]   cur_tbl;
  logic               status;
  logic [ENTRY_W-1:0] rdata_q;

  logic [SLOT_W-1:0]  slot_sel;
  logic [MEM_AW-1:0]  walk_addr;
  logic [PAGE_W-1:0]  entry_pg;
  logic               linked;
  logic [TBL_W-1:0]   link_tbl;
  logic [TBL_W-1:0]   alloc_tbl;
  logic [ENTRY_W-1:0] link_entry;
  logic               accept;

  function automatic logic [CNT_W-1:0] reload_free(input logic [POOL_W-1:0] pt);
    logic [POOL_W-1:0] f;
    f = (pt != '0) ? pt - 1'b1 : '0;
    return (f > POOL_W'(MAX_FREE)) ? CNT_W'(MAX_FREE) : CNT_W'(f);
  endfunction

  always_comb begin
    priority if (is_read) begin
      slot_sel = rd_slot;
    end else if (lvl == 2'd0) begin
      slot_sel = idx4;
    end else if (lvl == 2'd1) begin
      slot_sel = va_pg[3*SLOT_W-1:2*SLOT_W];
    end else begin
      slot_sel = va_pg[2*SLOT_W-1:SLOT_W];
    end
  end

  assign walk_addr  = {cur_tbl, slot_sel};
  assign entry_pg   = mem_rdata[ENTRY_W-1:OFS_W];
  assign linked     = (entry_pg != '0);
  assign link_tbl   = TBL_W'(entry_pg - pool_base);
  assign alloc_tbl  = (pool_tables >= {1'b0, free_cnt}) ?
                      TBL_W'(pool_tables - {1'b0, free_cnt}) : '0;
  assign link_entry = {PAGE_W'(pool_base + PAGE_W'(alloc_tbl)), LINK_FLAGS};

  always_comb begin
    mem_cmd.we    = 1'b0;
    mem_cmd.waddr = walk_addr;
    mem_cmd.wdata = link_entry;
    mem_cmd.raddr = walk_addr;
    unique case (state)
      S_CLEAR: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = clr_addr;
        mem_cmd.wdata = '0;
      end
      S_EV: begin
        mem_cmd.we = !is_read && !linked;
      end
      S_LEAF: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = {cur_tbl, va_pg[SLOT_W-1:0]};
        mem_cmd.wdata = {va_pg, attr};
      end
      default: begin
        mem_cmd.we = 1'b0;
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_DONE);
  assign res_item  = '{status: status, read_data: rdata_q, tables_free: free_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      pool_base   <= '0;
      pool_tables <= POOL_RESET;
      free_cnt    <= reload_free(POOL_RESET);
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            is_read <= (in_item.req_type == REQ_READ);
            va_pg   <= in_item.virt_addr[47:OFS_W];
            attr    <= in_item.page_attr;
            idx4    <= in_item.virt_addr[47:39] +
                       (in_item.high_half ? HIGH_HALF_OFFSET : '0);
            rd_slot <= in_item.read_slot;
            lvl     <= '0;
            cur_tbl <= (in_item.req_type == REQ_READ) ? TBL_W'(in_item.read_table) : '0;
            rdata_q <= '0;
            if (in_item.req_type == REQ_MAP && free_cnt <= MIN_FREE) begin
              status <= STATUS_REJECT;
              state  <= S_DONE;
            end else begin
              status <= STATUS_DONE;
              state  <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_EV;
        end
        S_EV: begin
          if (is_read) begin
            rdata_q <= mem_rdata;
            state   <= S_DONE;
          end else begin
            if (linked) begin
              cur_tbl <= link_tbl;
            end else begin
              cur_tbl  <= alloc_tbl;
              free_cnt <= free_cnt - 1'b1;
            end
            lvl   <= lvl + 1'b1;
            state <= (lvl == LVL_LAST) ? S_LEAF : S_RD;
          end
        end
        S_LEAF: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
      if (cfg_we) begin
        if (cfg_index == CFG_POOL_BASE) begin
          pool_base <= cfg_data[PAGE_W-1:0];
        end else begin
          pool_tables <= cfg_data[POOL_W-1:0];
          free_cnt    <= reload_free(cfg_data[POOL_W-1:0]);
        end
      end
    end
  end

endmodule

>>> rtl/core/four_level_page_table_builder_core.sv
// Builds four-level page tables in an on-chip pool of 512-entry tables, pool table 0 being
// the top level. After reset the table store is swept to zero, one entry per cycle, while
// req.ready stays low; configuration writes are taken during the sweep. The tables live
// in one memory with one write and one registered read port, and every level of a walk
// needs the entry read at the level before. A map passes a read state and an evaluate
// state for each of levels 4, 3 and 2, then the leaf write and the result state; a read
// passes read and evaluate once; a rejected map goes straight to the result state. One
// request is in work at a time; a finished item waits in the output register until taken.
module four_level_page_table_builder_core (
  input  logic                           clk,
  input  logic                           rst,
  fptb_req_if.sink                       req,
  fptb_rsp_if.source                     rsp,
  input  logic                           cfg_we,
  input  logic [fptb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fptb_pkg::CFG_W-1:0]     cfg_data
);
  import fptb_pkg::*;

  req_t               req_item;
  res_t               res_item;
  res_t               out_item;
  mem_cmd_t           mem_cmd;
  logic [ENTRY_W-1:0] mem_rdata;
  logic               res_valid;
  logic               res_ready;
  logic               out_valid;

  assign req_item = '{req_type:   req.req_type,
                      virt_addr:  req.virt_addr,
                      high_half:  req.high_half,
                      page_attr:  req.page_attr,
                      read_table: req.read_table,
                      read_slot:  req.read_slot};

  fptb_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_item   (req_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .mem_cmd   (mem_cmd),
    .mem_rdata (mem_rdata)
  );

  fptb_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_cmd.we),
    .waddr (mem_cmd.waddr),
    .wdata (mem_cmd.wdata),
    .raddr (mem_cmd.raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
      if (res_valid) begin
        out_item <= res_item;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_item.status;
  assign rsp.read_data   = out_item.read_data;
  assign rsp.tables_free = out_item.tables_free;

endmodule

>>> rtl/core/fptb_check.sv
module fptb_check (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_status,
  input logic [47:0] rsp_read_data,
  input logic [7:0]  rsp_tables_free
);

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("request taken right after reset");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in work");

  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status |-> rsp_read_data == 48'd0 && rsp_tables_free <= 8'd3)
    else $error("rejected map with data or a roomy pool");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
    $stable(rsp_tables_free) && $stable(rsp_status))
    else $error("stalled item changed or dropped");

endmodule

bind four_level_page_table_builder_core fptb_check u_check (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_read_data   (rsp.read_data),
  .rsp_tables_free (rsp.tables_free)
);

>>> tb/sv/four_level_page_table_builder_core_test.sv
module four_level_page_table_builder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fptb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  fptb_req_if req_ch ();
  fptb_rsp_if rsp_ch ();

  four_level_page_table_builder_core i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // mirror of the table pool and the allocator
  bit [ENTRY_W-1:0] pt_mem [MEM_DEPTH];
  logic [PAGE_W-1:0] m_base = '0;
  logic [POOL_W-1:0] m_pool = POOL_RESET;
  logic [CNT_W-1:0] m_free = 8'(MAX_FREE);

  res_t walk_exp_q [$];
  logic [MEM_AW-1:0] touched_q [$];
  logic [SLOT_W-1:0] hot_idx [3][4];

  int burst_left = 0;
  bit rsp_hold_req = 1'b0;
  int err_count = 0;
  int n_map = 0, n_read = 0, n_reject = 0, n_alloc = 0, n_cfg = 0, n_checked = 0;

  function automatic void note_touched(input logic [MEM_AW-1:0] ea);
    touched_q.push_back(ea);
    if (touched_q.size() > 64) void'(touched_q.pop_front());
  endfunction

  // follow the link in entry ea, or take the next free table and link it
  function automatic logic [TBL_W-1:0] follow_or_link(input logic [MEM_AW-1:0] ea);
    logic [PAGE_W-1:0] pg;
    logic [TBL_W-1:0] t;
    note_touched(ea);
    if (pt_mem[ea][ENTRY_W-1:OFS_W] != '0) begin
      pg = pt_mem[ea][ENTRY_W-1:OFS_W] - m_base;
      return pg[TBL_W-1:0];
    end
    t = (m_pool >= m_free) ? TBL_W'(m_pool - m_free) : '0;
    m_free = m_free - 1'b1;
    pg = m_base + t;
    pt_mem[ea] = {pg, LINK_FLAGS};
    n_alloc++;
    return t;
  endfunction

  function automatic res_t predict_walk(input req_t r);
    res_t o;
    logic [SLOT_W-1:0] i4;
    logic [TBL_W-1:0] t;
    logic [MEM_AW-1:0] leaf;
    o = '0;
    o.status = STATUS_DONE;
    if (r.req_type == REQ_READ) begin
      n_read++;
      o.read_data = pt_mem[{r.read_table, r.read_slot}];
    end else if (m_free <= MIN_FREE) begin
      n_map++;
      n_reject++;
      o.status = STATUS_REJECT;
    end else begin
      n_map++;
      i4 = r.virt_addr[47:39] + (r.high_half ? HIGH_HALF_OFFSET : '0);
      t = follow_or_link({TBL_W'(0), i4});
      t = follow_or_link({t, r.virt_addr[38:30]});
      t = follow_or_link({t, r.virt_addr[29:21]});
      leaf = {t, r.virt_addr[20:12]};
      pt_mem[leaf] = {r.virt_addr[47:12], r.page_attr};
      note_touched(leaf);
    end
    o.tables_free = m_free;
    return o;
  endfunction

  function automatic req_t map_item(input logic [47:0] va, input logic hh,
                                    input logic [ATTR_W-1:0] attr);
    req_t r;
    r = '0;
    r.req_type = REQ_MAP;
    r.virt_addr = va;
    r.high_half = hh;
    r.page_attr = attr;
    r.read_table = 8'hff;
    r.read_slot = 9'h1ff;
    return r;
  endfunction

  function automatic req_t read_item(input logic [RTBL_W-1:0] tbl,
                                     input logic [SLOT_W-1:0] slot);
    req_t r;
    r = '0;
    r.req_type = REQ_READ;
    r.virt_addr = 48'hffff_ffff_ffff;
    r.high_half = 1'b1;
    r.page_attr = 12'hfff;
    r.read_table = tbl;
    r.read_slot = slot;
    return r;
  endfunction

  function automatic void pick_hot_regions();
    for (int lv = 0; lv < 3; lv++)
      for (int k = 0; k < 4; k++)
        hot_idx[lv][k] = SLOT_W'($urandom);
  endfunction

  // mostly walks through a few shared regions, plus reads of entries written lately
  function automatic req_t make_item();
    req_t r;
    int pick;
    logic [MEM_AW-1:0] ea;
    r.req_type = REQ_MAP;
    r.virt_addr = 48'({$urandom, $urandom});
    r.high_half = 1'($urandom);
    r.page_attr = ATTR_W'($urandom);
    r.read_table = RTBL_W'($urandom);
    r.read_slot = SLOT_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      r.virt_addr[47:39] = hot_idx[0][$urandom_range(0, 3)];
      r.virt_addr[38:30] = hot_idx[1][$urandom_range(0, 3)];
      r.virt_addr[29:21] = hot_idx[2][$urandom_range(0, 3)];
    end else if (pick >= 70) begin
      r.req_type = REQ_READ;
      if (pick < 95 && touched_q.size() > 0) begin
        ea = touched_q[$urandom_range(0, touched_q.size() - 1)];
        r.read_table = ea[MEM_AW-1:SLOT_W];
        r.read_slot = ea[SLOT_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic send_item(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r.req_type;
    req_ch.virt_addr <= r.virt_addr;
    req_ch.high_half <= r.high_half;
    req_ch.page_attr <= r.page_attr;
    req_ch.read_table <= r.read_table;
    req_ch.read_slot <= r.read_slot;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    walk_exp_q.push_back(predict_walk(r));
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (walk_exp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_cfg++;
    if (idx == CFG_POOL_BASE) begin
      m_base = val[PAGE_W-1:0];
    end else begin
      m_pool = val[POOL_W-1:0];
      if (m_pool == 0) m_free = '0;
      else if (m_pool - 1 > MAX_FREE) m_free = 8'(MAX_FREE);
      else m_free = 8'(m_pool - 1);
    end
  endtask

  task automatic random_traffic(input int n);
    for (int k = 0; k < n; k++) begin
      if (k % 60 == 0) pick_hot_regions();
      send_item(make_item());
    end
  endtask

  task automatic test_directed_walk();
    send_item(read_item(8'd0, 9'd0));
    send_item(read_item(8'hff, 9'h1ff));
    send_item(map_item(48'h0000_0000_0000, 1'b0, 12'h000));
    send_item(map_item(48'hffff_ffff_ffff, 1'b1, 12'hfff));
    send_item(map_item(48'h0000_0000_1abc, 1'b0, 12'h5a5));
    send_item(map_item(48'h8000_0020_0000, 1'b1, 12'h0a0));
    send_item(read_item(8'd0, 9'd0));
    send_item(read_item(8'd0, 9'd255));
    send_item(read_item(8'd3, 9'd1));
    send_item(read_item(8'd3, 9'd0));
  endtask

  task automatic test_pool_limits();
    wait_drained();
    write_cfg(CFG_POOL_TABLES, CFG_W'(5));
    send_item(map_item(48'h0123_4560_0000, 1'b0, 12'h067));
    send_item(map_item(48'h7fff_ffff_f000, 1'b0, 12'h001));
    send_item(read_item(8'd1, 9'd0));
    wait_drained();
    write_cfg(CFG_POOL_TABLES, CFG_W'(4));
    send_item(map_item(48'h0000_0000_2000, 1'b0, 12'h003));
    send_item(read_item(8'd0, 9'd4));
  endtask

  // link to base + 1 wraps to page zero, so that entry still looks empty
  task automatic test_base_wrap();
    wait_drained();
    write_cfg(CFG_POOL_TABLES, CFG_W'(256));
    write_cfg(CFG_POOL_BASE, 36'hf_ffff_ffff);
    send_item(map_item(48'h0280_0000_0000, 1'b0, 12'h007));
    send_item(map_item(48'h0280_4030_2000, 1'b0, 12'h800));
    send_item(read_item(8'd0, 9'd5));
    wait_drained();
    write_cfg(CFG_POOL_BASE, 36'h1_2345_6789);
    send_item(map_item(48'h0000_0000_3000, 1'b0, 12'h111));
    send_item(read_item(8'd0, 9'd0));
  endtask

  task automatic test_random_default_pool();
    wait_drained();
    write_cfg(CFG_POOL_BASE, '0);
    write_cfg(CFG_POOL_TABLES, CFG_W'(256));
    random_traffic(250);
  endtask

  task automatic test_random_small_pool();
    wait_drained();
    write_cfg(CFG_POOL_TABLES, CFG_W'(40));
    write_cfg(CFG_POOL_BASE, CFG_W'({$urandom_range(0, 15), $urandom}));
    random_traffic(200);
  endtask

  task automatic test_random_max_base();
    wait_drained();
    write_cfg(CFG_POOL_TABLES, CFG_W'(256));
    write_cfg(CFG_POOL_BASE, 36'hf_ffff_ffff);
    random_traffic(200);
  endtask

  task automatic test_random_mixed_config();
    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      write_cfg(CFG_POOL_TABLES, CFG_W'($urandom_range(4, 256)));
      write_cfg(CFG_POOL_BASE, CFG_W'({$urandom_range(0, 15), $urandom}));
      random_traffic(50);
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    write_cfg(CFG_POOL_TABLES, CFG_W'(256));
    write_cfg(CFG_POOL_BASE, '0);
    random_traffic(10);
    rsp_hold_req = 1'b1;
    random_traffic(40);
  endtask

  // receiver: changing stall patterns, plus a long hold-off on request
  initial begin : rsp_stall
    int mode, left, hold_left, cyc;
    mode = 0;
    left = 0;
    hold_left = 0;
    cyc = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 150);
        end
        left--;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= (cyc % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got.status = rsp_ch.status;
      got.read_data = rsp_ch.read_data;
      got.tables_free = rsp_ch.tables_free;
      if (walk_exp_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("error: unexpected result status=%0b data=%h free=%0d",
                   got.status, got.read_data, got.tables_free);
      end else begin
        want = walk_exp_q.pop_front();
        n_checked++;
        if (got.status !== want.status || got.read_data !== want.read_data ||
            got.tables_free !== want.tables_free) begin
          err_count++;
          if (err_count <= 10)
            $display("error: result %0d expected status=%0b data=%h free=%0d, got status=%0b data=%h free=%0d",
                     n_checked, want.status, want.read_data, want.tables_free,
                     got.status, got.read_data, got.tables_free);
        end
      end
    end
  end

  initial begin : run_limit
    #15_000_000;
    $display("error: run did not finish in time");
    $display("tb: failure");
    $finish;
  end

  initial begin : main
    int spin;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_MAP;
    req_ch.virt_addr <= '0;
    req_ch.high_half <= 1'b0;
    req_ch.page_attr <= '0;
    req_ch.read_table <= '0;
    req_ch.read_slot <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_POOL_BASE;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_walk();
    test_pool_limits();
    test_base_wrap();
    test_random_default_pool();
    test_random_small_pool();
    test_random_max_base();
    test_random_mixed_config();
    test_backpressure();

    req_ch.valid <= 1'b0;
    spin = 0;
    while (walk_exp_q.size() != 0 && spin < 5000) begin
      @(posedge clk);
      spin++;
    end
    repeat (20) @(posedge clk);
    if (walk_exp_q.size() != 0) begin
      $display("error: %0d results never arrived", walk_exp_q.size());
      err_count += walk_exp_q.size();
    end
    $display("summary: %0d maps (%0d rejected), %0d reads, %0d tables linked",
             n_map, n_reject, n_read, n_alloc);
    $display("summary: %0d register writes, %0d results checked, %0d errors",
             n_cfg, n_checked, err_count);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
